/* rtl/core/cost_grid_with_threshold_defines.svh */
// Assertion macros for the cost grid block.
// Used by the top level; no other dependencies.
`ifndef COST_GRID_WITH_THRESHOLD_DEFINES_SVH
`define COST_GRID_WITH_THRESHOLD_DEFINES_SVH
// clocked implication, disabled during reset
`define CG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define CG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/core/cgt_pkg.sv */
// Shared constants and types for the cost grid block.
// No dependencies.
package cgt_pkg;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int COST_BITS   = 16;
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CNT_W  = 9;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_FILL  = 3'd1;
  localparam logic [2:0] OP_SET   = 3'd2;
  localparam logic [2:0] OP_GET   = 3'd3;
  localparam logic [2:0] OP_SCAN  = 3'd4;
  localparam logic [2:0] OP_SETTH = 3'd5;

  localparam logic [2:0] REG_LEFT = 3'd0;
  localparam logic [2:0] REG_TOP  = 3'd1;
  localparam logic [2:0] REG_CW   = 3'd2;
  localparam logic [2:0] REG_CH   = 3'd3;
  localparam logic [2:0] REG_COLS = 3'd4;
  localparam logic [2:0] REG_ROWS = 3'd5;

  typedef struct packed {
    logic start;
    logic signed [16:0] a;
    logic signed [16:0] b;
    logic [10:0] size;
    logic [CNT_W-1:0] limit;
  } span_req_t;

  typedef struct packed {
    logic done;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;
  } span_rsp_t;
endpackage

/* rtl/core/cgt_span.sv */
// Maps a world span to a clamped half-open cell range.
// Two restoring dividers, one quotient bit per cycle. Depends on cgt_pkg.
module cgt_span (
  input  logic clk,
  input  logic rst,
  input  cgt_pkg::span_req_t req,
  output cgt_pkg::span_rsp_t rsp
);
  localparam int CNT_W_L = cgt_pkg::CNT_W;
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_FIX} st_t;
  st_t st;
  logic [16:0] mag_lo, mag_hi, q_lo, q_hi;
  logic [10:0] r_lo, r_hi, d;
  logic neg_lo, neg_hi;
  logic [4:0] bitn;
  logic [CNT_W_L-1:0] lim;
  logic signed [17:0] mn, mx;
  logic [11:0] t_lo, t_hi;
  logic signed [18:0] lo_s, hi_s;

  always_comb begin
    mn = (req.a < req.b) ? 18'(req.a) : 18'(req.b);
    mx = (req.a < req.b) ? 18'(req.b) : 18'(req.a);
    t_lo = {r_lo, mag_lo[16]};
    t_hi = {r_hi, mag_hi[16]};
    // floor for low edge, ceil for high edge, on sign-magnitude quotients
    lo_s = neg_lo ? -19'($signed({2'b0, q_lo})) - 19'((r_lo != 0) ? 1 : 0)
                  : 19'($signed({2'b0, q_lo}));
    hi_s = neg_hi ? -19'($signed({2'b0, q_hi}))
                  : 19'($signed({2'b0, q_hi})) + 19'((r_hi != 0) ? 1 : 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (st)
        S_IDLE: if (req.start) begin
          neg_lo <= mn[17];
          neg_hi <= mx[17];
          mag_lo <= mn[17] ? 17'(-mn) : mn[16:0];
          mag_hi <= mx[17] ? 17'(-mx) : mx[16:0];
          d <= (req.size == 0) ? 11'd1 : req.size;
          lim <= req.limit;
          r_lo <= '0; r_hi <= '0; q_lo <= '0; q_hi <= '0;
          bitn <= 5'd16;
          st <= S_DIV;
        end
        S_DIV: begin
          mag_lo <= {mag_lo[15:0], 1'b0};
          mag_hi <= {mag_hi[15:0], 1'b0};
          if (t_lo >= {1'b0, d}) begin
            r_lo <= 11'(t_lo - {1'b0, d}); q_lo <= {q_lo[15:0], 1'b1};
          end else begin
            r_lo <= t_lo[10:0]; q_lo <= {q_lo[15:0], 1'b0};
          end
          if (t_hi >= {1'b0, d}) begin
            r_hi <= 11'(t_hi - {1'b0, d}); q_hi <= {q_hi[15:0], 1'b1};
          end else begin
            r_hi <= t_hi[10:0]; q_hi <= {q_hi[15:0], 1'b0};
          end
          if (bitn == 0) st <= S_FIX;
          else bitn <= bitn - 5'd1;
        end
        S_FIX: begin
          rsp.lo <= lo_s[18] ? '0 :
                    (lo_s > 19'($signed({10'b0, lim}))) ? lim : lo_s[CNT_W_L-1:0];
          rsp.hi <= hi_s[18] ? '0 :
                    (hi_s > 19'($signed({10'b0, lim}))) ? lim : hi_s[CNT_W_L-1:0];
          rsp.done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

/* rtl/core/cost_grid_with_threshold.sv */
// Cost grid with threshold: top level.
// Depends on cgt_pkg, cgt_span and cost_grid_with_threshold_defines.svh.
//
// Usage: one request on the opcode/corner/cell/cost input channel yields one
// result (cell_cost, threshold_now, status) on the output channel; both are
// valid/ready. Configuration writes use cfg_valid/cfg_ready with cfg_index
// and cfg_data, and are taken only while no request is in flight.
// Steps per operation, one request at a time:
//   set threshold, read threshold: no memory access
//   get cell: one memory read; set cell: one memory read, one write-back
//   clear all: one memory write per cell of the whole memory
//   rescan: one memory read per cell in use
//   fill: span division (x then y), then a read and a write per cell touched.
// The result register holds until taken; a stalled receiver blocks the next
// request.
// Reset clears threshold and registers; cell memory is undefined
// until written and gets no clearing pass.
`include "cost_grid_with_threshold_defines.svh"
module cost_grid_with_threshold (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] opcode,
  input  logic signed [15:0] corner_x1,
  input  logic signed [15:0] corner_y1,
  input  logic signed [15:0] corner_x2,
  input  logic signed [15:0] corner_y2,
  input  logic [5:0] cell_column,
  input  logic [5:0] cell_row,
  input  logic [15:0] cost_value,
  output logic out_valid,
  input  logic out_ready,
  output logic [15:0] cell_cost,
  output logic [15:0] threshold_now,
  output logic status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int CB = cgt_pkg::COST_BITS;
  localparam int AW = cgt_pkg::ADDR_W;
  localparam int CW = cgt_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_WB, ST_SPANX, ST_SPANY, ST_FRD, ST_FWR,
    ST_CLR, ST_SCAN, ST_SCANL, ST_OUT
  } st_t;
  st_t st;

  logic [CB-1:0] mem [0:(1<<AW)-1];
  logic [CB-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CB-1:0] wdata;

  logic signed [15:0] grid_left, grid_top;
  logic [10:0] cell_width, cell_height;
  logic [6:0] columns_used, rows_used;

  logic [2:0] op;
  logic [CB-1:0] cost, thr, mx;
  logic [cgt_pkg::COL_W-1:0] col;
  logic [cgt_pkg::ROW_W-1:0] row;
  logic signed [15:0] x1, y1, x2, y2;
  logic [CW-1:0] x0, xe, y0, ye, xi, yi;
  logic [AW:0] cnt;
  logic scan_vld;

  cgt_pkg::span_req_t sreq;
  cgt_pkg::span_rsp_t srsp;

  logic [CW-1:0] cols, rows;
  logic oob;

  assign cols = (columns_used > 7'(cgt_pkg::MAX_COLUMNS)) ? CW'(cgt_pkg::MAX_COLUMNS)
                                                         : CW'(columns_used);
  assign rows = (rows_used > 7'(cgt_pkg::MAX_ROWS)) ? CW'(cgt_pkg::MAX_ROWS)
                                                   : CW'(rows_used);
  assign oob = (CW'(col) >= cols) || (CW'(row) >= rows);
  assign in_ready = (st == ST_IDLE) && !out_valid;
  assign cfg_ready = (st == ST_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  cgt_span u_span (.clk(clk), .rst(rst), .req(sreq), .rsp(srsp));

  always_comb begin
    sreq.start = (st == ST_SPANX || st == ST_SPANY) && (cnt == '0);
    sreq.a = (st == ST_SPANX) ? 17'(x1) - 17'(grid_left) : 17'(y1) - 17'(grid_top);
    sreq.b = (st == ST_SPANX) ? 17'(x2) - 17'(grid_left) : 17'(y2) - 17'(grid_top);
    sreq.size = (st == ST_SPANX) ? cell_width : cell_height;
    sreq.limit = (st == ST_SPANX) ? cols : rows;
    raddr = '0;
    case (st)
      ST_IDLE: raddr = {cell_column, cell_row};
      ST_RD:   raddr = {col, row};
      ST_FRD:  raddr = {xi[cgt_pkg::COL_W-1:0], yi[cgt_pkg::ROW_W-1:0]};
      ST_SCAN: raddr = {xi[cgt_pkg::COL_W-1:0], yi[cgt_pkg::ROW_W-1:0]};
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      out_valid <= 1'b0;
      we <= 1'b0;
      thr <= '0;
      grid_left <= '0; grid_top <= '0;
      cell_width <= 11'd16; cell_height <= 11'd16;
      columns_used <= 7'd64; rows_used <= 7'd64;
      cnt <= '0;
      scan_vld <= 1'b0;
    end else begin
      we <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cgt_pkg::REG_LEFT: grid_left <= cfg_data;
          cgt_pkg::REG_TOP:  grid_top <= cfg_data;
          cgt_pkg::REG_CW:   cell_width <= cfg_data[10:0];
          cgt_pkg::REG_CH:   cell_height <= cfg_data[10:0];
          cgt_pkg::REG_COLS: columns_used <= cfg_data[6:0];
          cgt_pkg::REG_ROWS: rows_used <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (st)
        ST_IDLE: if (in_valid && in_ready) begin
          op <= opcode; cost <= CB'(cost_value);
          col <= cell_column; row <= cell_row;
          x1 <= corner_x1; y1 <= corner_y1; x2 <= corner_x2; y2 <= corner_y2;
          cell_cost <= '0; status <= 1'b0;
          cnt <= '0; mx <= '0; xi <= '0; yi <= '0; scan_vld <= 1'b0;
          case (opcode)
            cgt_pkg::OP_CLEAR: st <= ST_CLR;
            cgt_pkg::OP_FILL:  st <= ST_SPANX;
            cgt_pkg::OP_SET,
            cgt_pkg::OP_GET:   st <= ST_RD;
            cgt_pkg::OP_SCAN:  st <= ST_SCAN;
            cgt_pkg::OP_SETTH: begin thr <= CB'(cost_value); st <= ST_OUT; end
            default: st <= ST_OUT;
          endcase
        end
        ST_RD: st <= ST_WB;  // read data lands this cycle
        ST_WB: begin
          if (oob) status <= 1'b1;
          else if (op == cgt_pkg::OP_GET) cell_cost <= rdata;
          else begin
            we <= 1'b1; waddr <= {col, row}; wdata <= cost;
            if (rdata > thr || cost > thr) thr <= (rdata > cost) ? rdata : cost;
          end
          st <= ST_OUT;
        end
        ST_SPANX: begin
          cnt <= (AW+1)'(1);
          if (srsp.done) begin x0 <= srsp.lo; xe <= srsp.hi; cnt <= '0; st <= ST_SPANY; end
        end
        ST_SPANY: begin
          cnt <= (AW+1)'(1);
          if (srsp.done) begin
            y0 <= srsp.lo; ye <= srsp.hi; xi <= x0; yi <= srsp.lo; mx <= cost;
            st <= (x0 < xe && srsp.lo < srsp.hi) ? ST_FRD : ST_OUT;
            if (!(x0 < xe && srsp.lo < srsp.hi) && cost > thr) thr <= cost;
          end
        end
        ST_FRD: st <= ST_FWR;
        ST_FWR: begin
          we <= 1'b1;
          waddr <= {xi[cgt_pkg::COL_W-1:0], yi[cgt_pkg::ROW_W-1:0]};
          wdata <= cost;
          if (yi + 1 < ye) begin
            yi <= yi + CW'(1); st <= ST_FRD;
            if (rdata > mx) mx <= rdata;
          end else if (xi + 1 < xe) begin
            yi <= y0; xi <= xi + CW'(1); st <= ST_FRD;
            if (rdata > mx) mx <= rdata;
          end else begin
            if (rdata > mx && rdata > thr) thr <= rdata;
            else if (mx > thr) thr <= mx;
            st <= ST_OUT;
          end
        end
        ST_CLR: begin
          we <= 1'b1; waddr <= cnt[AW-1:0]; wdata <= cost;
          cnt <= cnt + (AW+1)'(1);
          if (cnt == AW'((1<<AW)-1)) begin thr <= cost; st <= ST_OUT; end
        end
        ST_SCAN: begin
          // address issued now; data compared in the following cycle
          if (scan_vld && rdata > mx) mx <= rdata;
          if (cols == 0 || rows == 0) begin thr <= '0; st <= ST_OUT; end
          else begin
            scan_vld <= 1'b1;
            if (yi + 1 < rows) yi <= yi + CW'(1);
            else if (xi + 1 < cols) begin yi <= '0; xi <= xi + CW'(1); end
            else st <= ST_SCANL;
          end
        end
        ST_SCANL: begin
          thr <= (rdata > mx) ? rdata : mx;
          st <= ST_OUT;
        end
        ST_OUT: begin out_valid <= 1'b1; st <= ST_IDLE; end
        default: st <= ST_IDLE;
      endcase
    end
  end

  assign threshold_now = 16'(thr);

  `CG_ASSERT_IMP(a_ready_idle, in_ready, st == ST_IDLE, "ready outside idle")
  `CG_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
  `CG_ASSERT_NEXT(a_one_req, in_valid && in_ready, !in_ready, "second request taken")
  `CG_ASSERT_IMP(a_no_write_idle, st == ST_IDLE && out_valid, !we, "write while done")
endmodule

/* sim/cost_grid_with_threshold_tb.sv */
// Self-checking testbench for cost_grid_with_threshold: directed table, then random phases.
// Depends on cgt_pkg and the cost_grid_with_threshold RTL; predicts results the table does not give.
`timescale 1ns / 100ps
module cost_grid_with_threshold_tb;
  localparam logic [2:0] OP_READ_TH = 3'd6;
  localparam logic [2:0] OP_UNUSED  = 3'd7;
  localparam int GRID_CELLS = cgt_pkg::MAX_COLUMNS * cgt_pkg::MAX_ROWS;
  localparam int STALL_LIMIT = 60000;
  localparam int PHASES = 6;
  localparam int RANDOM_PER_PHASE = 314;

  typedef struct {
    logic [2:0] op;
    logic signed [15:0] x1, y1, x2, y2;
    logic [5:0] col, row;
    logic [15:0] cost;
  } request_t;

  typedef struct {
    logic [15:0] cost;
    logic [15:0] thr;
    logic st;
  } answer_t;

  typedef struct {
    request_t req;
    bit known;
    answer_t ans;
  } table_row_t;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  logic [2:0] opcode, cfg_index;
  logic signed [15:0] corner_x1, corner_y1, corner_x2, corner_y2;
  logic [5:0] cell_column, cell_row;
  logic [15:0] cost_value, cell_cost, threshold_now, cfg_data;
  logic status;

  cost_grid_with_threshold dut (.*);

  // shadow of the block's state
  logic [15:0] grid_mem [GRID_CELLS];
  logic [15:0] thr_reg;
  logic [15:0] left_reg, top_reg;
  logic [10:0] cw_reg, ch_reg;
  logic [6:0] cols_reg, rows_reg;

  answer_t pending_answers [$];
  int errors = 0;
  int accepted = 0;
  int answered = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_go = 0, hold_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int want, input int got);
    $display("mismatch %s: expected %0h got %0h (result %0d)", what, want, got, answered);
    errors++;
  endtask

  function automatic int cols_in_use();
    return cols_reg > cgt_pkg::MAX_COLUMNS ? cgt_pkg::MAX_COLUMNS : int'(cols_reg);
  endfunction

  function automatic int rows_in_use();
    return rows_reg > cgt_pkg::MAX_ROWS ? cgt_pkg::MAX_ROWS : int'(rows_reg);
  endfunction

  // half-open cell range covered by world span a..b
  function automatic void cover_span(input int a, input int b, input int origin,
                                     input int size, input int limit,
                                     output int lo, output int hi);
    int d, pa, pb, mn, mx;
    d = (size == 0) ? 1 : size;
    pa = a - origin;
    pb = b - origin;
    mn = pa < pb ? pa : pb;
    mx = pa < pb ? pb : pa;
    lo = mn / d;
    if (mn % d != 0 && mn < 0) lo--;
    hi = mx / d;
    if (mx % d != 0 && mx > 0) hi++;
    if (lo < 0) lo = 0;
    if (hi > limit) hi = limit;
  endfunction

  function automatic answer_t grid_step(input request_t r);
    answer_t a;
    int x0, x1, y0, y1, top;
    int cols, rows;
    cols = cols_in_use();
    rows = rows_in_use();
    a.cost = 0;
    a.st = 0;
    case (r.op)
      cgt_pkg::OP_CLEAR: begin
        foreach (grid_mem[i]) grid_mem[i] = r.cost;
        thr_reg = r.cost;
      end
      cgt_pkg::OP_FILL: begin
        top = 0;
        cover_span(r.x1, r.x2, $signed(left_reg), cw_reg, cols, x0, x1);
        cover_span(r.y1, r.y2, $signed(top_reg), ch_reg, rows, y0, y1);
        for (int x = x0; x < x1; x++)
          for (int y = y0; y < y1; y++) begin
            if (grid_mem[x * cgt_pkg::MAX_ROWS + y] > top)
              top = int'(grid_mem[x * cgt_pkg::MAX_ROWS + y]);
            grid_mem[x * cgt_pkg::MAX_ROWS + y] = r.cost;
          end
        if (r.cost > top) top = int'(r.cost);
        if (thr_reg < top) thr_reg = 16'(top);
      end
      cgt_pkg::OP_SET: begin
        if (r.col >= cols || r.row >= rows) a.st = 1;
        else begin
          top = int'(grid_mem[r.col * cgt_pkg::MAX_ROWS + r.row]);
          grid_mem[r.col * cgt_pkg::MAX_ROWS + r.row] = r.cost;
          if (r.cost > top) top = int'(r.cost);
          if (thr_reg < top) thr_reg = 16'(top);
        end
      end
      cgt_pkg::OP_GET: begin
        if (r.col >= cols || r.row >= rows) a.st = 1;
        else a.cost = grid_mem[r.col * cgt_pkg::MAX_ROWS + r.row];
      end
      cgt_pkg::OP_SCAN: begin
        top = 0;
        for (int x = 0; x < cols; x++)
          for (int y = 0; y < rows; y++)
            if (grid_mem[x * cgt_pkg::MAX_ROWS + y] > top)
              top = int'(grid_mem[x * cgt_pkg::MAX_ROWS + y]);
        thr_reg = 16'(top);
      end
      cgt_pkg::OP_SETTH: thr_reg = r.cost;
      default: ;
    endcase
    a.thr = thr_reg;
    return a;
  endfunction

  // offer one request; valid stays high unless an idle gap follows
  task automatic offer(input request_t r, input bit known, input answer_t typed);
    answer_t a;
    opcode <= r.op;
    corner_x1 <= r.x1;
    corner_y1 <= r.y1;
    corner_x2 <= r.x2;
    corner_y2 <= r.y2;
    cell_column <= r.col;
    cell_row <= r.row;
    cost_value <= r.cost;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    a = grid_step(r);
    pending_answers = {pending_answers, known ? typed : a};
    accepted++;
    if ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      cgt_pkg::REG_LEFT: left_reg = val;
      cgt_pkg::REG_TOP:  top_reg = val;
      cgt_pkg::REG_CW:   cw_reg = val[10:0];
      cgt_pkg::REG_CH:   ch_reg = val[10:0];
      cgt_pkg::REG_COLS: cols_reg = val[6:0];
      cgt_pkg::REG_ROWS: rows_reg = val[6:0];
      default: ;
    endcase
  endtask

  // one corner coordinate near the grid on one axis
  function automatic logic signed [15:0] near_grid(input int origin, input int size,
                                                   input int count);
    int d, c;
    d = (size == 0) ? 1 : size;
    c = int'($urandom_range(0, count + 3)) - 2;
    return 16'(origin + c * d + int'($urandom_range(0, d - 1)));
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick, d;
    r.x1 = 16'($urandom);
    r.y1 = 16'($urandom);
    r.x2 = 16'($urandom);
    r.y2 = 16'($urandom);
    r.col = 6'($urandom_range(0, cols_in_use() + 2 > 63 ? 63 : cols_in_use() + 2));
    r.row = 6'($urandom_range(0, rows_in_use() + 2 > 63 ? 63 : rows_in_use() + 2));
    if ($urandom_range(0, 9) == 0) begin
      r.col = 6'($urandom);
      r.row = 6'($urandom);
    end
    r.cost = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 1) r.op = cgt_pkg::OP_CLEAR;
    else if (pick < 31) r.op = cgt_pkg::OP_FILL;
    else if (pick < 53) r.op = cgt_pkg::OP_SET;
    else if (pick < 78) r.op = cgt_pkg::OP_GET;
    else if (pick < 80) r.op = cgt_pkg::OP_SCAN;
    else if (pick < 88) r.op = cgt_pkg::OP_SETTH;
    else if (pick < 96) r.op = OP_READ_TH;
    else r.op = OP_UNUSED;
    // most fills stay small and near the grid; a few use raw corners
    if (r.op == cgt_pkg::OP_FILL && $urandom_range(0, 99) != 0) begin
      d = (cw_reg == 0) ? 1 : int'(cw_reg);
      r.x1 = near_grid($signed(left_reg), cw_reg, cols_in_use());
      r.x2 = 16'(int'(r.x1) + int'($urandom_range(0, 8 * d)) - 4 * d);
      d = (ch_reg == 0) ? 1 : int'(ch_reg);
      r.y1 = near_grid($signed(top_reg), ch_reg, rows_in_use());
      r.y2 = 16'(int'(r.y1) + int'($urandom_range(0, 8 * d)) - 4 * d);
    end
    return r;
  endfunction

  // result checking and receiver stalls
  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        answered++;
        if (pending_answers.size() == 0) begin
          report("unexpected result", 0, threshold_now);
        end else begin
          want = pending_answers.pop_front();
          if (cell_cost !== want.cost) report("cell_cost", want.cost, cell_cost);
          if (threshold_now !== want.thr) report("threshold_now", want.thr, threshold_now);
          if (status !== want.st) report("status", want.st, status);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  table_row_t directed [] = '{
    '{'{cgt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 16'h0000}, 1, '{16'h0000, 16'h0000, 0}},
    '{'{cgt_pkg::OP_SETTH, 0, 0, 0, 0, 0, 0, 16'hffff}, 1, '{16'h0000, 16'hffff, 0}},
    '{'{OP_READ_TH, 0, 0, 0, 0, 0, 0, 16'h0000}, 1, '{16'h0000, 16'hffff, 0}},
    '{'{cgt_pkg::OP_SET, 0, 0, 0, 0, 63, 63, 16'hffff}, 1, '{16'h0000, 16'hffff, 0}},
    '{'{cgt_pkg::OP_GET, 0, 0, 0, 0, 63, 63, 16'h0000}, 1, '{16'hffff, 16'hffff, 0}},
    '{'{cgt_pkg::OP_SETTH, 0, 0, 0, 0, 0, 0, 16'h0005}, 1, '{16'h0000, 16'h0005, 0}},
    '{'{cgt_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0, 16'h0000}, 1, '{16'h0000, 16'hffff, 0}},
    '{'{cgt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 16'h1234}, 1, '{16'h0000, 16'h1234, 0}},
    // whole plane, corner extremes
    '{'{cgt_pkg::OP_FILL, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 0, 0, 16'h8000},
      1, '{16'h0000, 16'h8000, 0}},
    // wholly left of the grid: nothing written, threshold still raised
    '{'{cgt_pkg::OP_FILL, -16'sd100, 0, -16'sd20, 16'sd10, 0, 0, 16'h9000},
      1, '{16'h0000, 16'h9000, 0}},
    // wholly above the grid, lower cost
    '{'{cgt_pkg::OP_FILL, 0, -16'sd50, 16'sd30, -16'sd1, 0, 0, 16'h0001},
      1, '{16'h0000, 16'h9000, 0}},
    '{'{cgt_pkg::OP_FILL, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 0, 0, 16'h0001}, 0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_FILL, 16'sd16, 16'sd16, 16'sd32, 16'sd48, 0, 0, 16'h0abc},
      0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_GET, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_GET, 0, 0, 0, 0, 1, 2, 16'h0000}, 0, '{0, 0, 0}},
    '{'{OP_UNUSED, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_SETTH, 0, 0, 0, 0, 0, 0, 16'h0000}, 1, '{16'h0000, 16'h0000, 0}},
    '{'{cgt_pkg::OP_SET, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_GET, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '{0, 0, 0}},
    // corners given high-to-low
    '{'{cgt_pkg::OP_FILL, 16'sd100, 16'sd40, -16'sd7, 16'sd3, 0, 0, 16'h0007},
      0, '{0, 0, 0}},
    '{'{cgt_pkg::OP_SCAN, 0, 0, 0, 0, 0, 0, 16'h0000}, 0, '{0, 0, 0}}
  };

  // left, top, cell width, cell height, columns, rows
  int phase_cfg [PHASES][6] = '{
    '{0, 0, 16, 16, 64, 64},
    '{-32768, 32767, 1, 1, 8, 12},
    '{32767, -32768, 1024, 1024, 64, 1},
    '{-100, 50, 0, 2047, 0, 127},
    '{37, -21, 7, 3, 16, 16},
    '{0, 0, 16, 16, 64, 64}
  };

  initial begin
    answer_t none;
    none = '{0, 0, 0};
    rst <= 1;
    in_valid <= 0;
    opcode <= cgt_pkg::OP_CLEAR;
    corner_x1 <= 0;
    corner_y1 <= 0;
    corner_x2 <= 0;
    corner_y2 <= 0;
    cell_column <= 0;
    cell_row <= 0;
    cost_value <= 0;
    cfg_valid <= 0;
    cfg_index <= cgt_pkg::REG_LEFT;
    cfg_data <= 0;
    thr_reg = 0;
    left_reg = 0;
    top_reg = 0;
    cw_reg = 16;
    ch_reg = 16;
    cols_reg = 64;
    rows_reg = 64;
    foreach (grid_mem[i]) grid_mem[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_idle = 36;
    recv_idle = 74;
    foreach (directed[i]) offer(directed[i].req, directed[i].known, directed[i].ans);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 2) begin
        send_idle = 74;
        recv_idle = 36;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      // registers change only with nothing in flight
      drain();
      if (p != 0) begin
        cfg_write(cgt_pkg::REG_LEFT, 16'(phase_cfg[p][0]));
        cfg_write(cgt_pkg::REG_TOP, 16'(phase_cfg[p][1]));
        cfg_write(cgt_pkg::REG_CW, 16'(phase_cfg[p][2]));
        cfg_write(cgt_pkg::REG_CH, 16'(phase_cfg[p][3]));
        cfg_write(cgt_pkg::REG_COLS, 16'(phase_cfg[p][4]));
        cfg_write(cgt_pkg::REG_ROWS, 16'(phase_cfg[p][5]));
        cfg_valid <= 0;
        @(posedge clk);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (p == 1 && n == 20) hold_go = 1;
        if (p == 0 && n == 150) drain();
        offer(random_request(), 0, none);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results, over %0d grid setups", accepted, answered,
             PHASES);
    $display("setups ranged over cell sizes 0..2047, origins at both extremes, 0..127 in use");
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_answers.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/cgt_pkg.sv
rtl/core/cgt_span.sv
rtl/core/cost_grid_with_threshold.sv
sim/cost_grid_with_threshold_tb.sv
